### rtl/b64e_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package b64e_pkg;

    localparam int unsigned JOB_DEPTH = 4;

    localparam logic [7:0] PAD_CHAR = 8'h3D;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } byte_item_t;

    typedef struct packed {
        logic [7:0] out_char;
        logic       last_char;
    } char_item_t;

    // One accepted byte turned into its characters (one to four).
    typedef struct packed {
        logic [3:0][7:0] chars;
        logic [1:0]      last_idx;
        logic            fin;
    } job_t;

    typedef enum logic [1:0] {
        PHASE_0 = 2'd0,
        PHASE_1 = 2'd1,
        PHASE_2 = 2'd2
    } phase_t;

    function automatic logic [7:0] b64_sym(input logic [5:0] six);
        logic [7:0] v;
        v = {2'b00, six};
        if (six < 6'd26) begin
            b64_sym = 8'h41 + v;
        end else if (six < 6'd52) begin
            b64_sym = 8'h61 + v - 8'd26;
        end else if (six < 6'd62) begin
            b64_sym = 8'h30 + v - 8'd52;
        end else if (six == 6'd62) begin
            b64_sym = 8'h2B;
        end else begin
            b64_sym = 8'h2F;
        end
    endfunction

endpackage

`default_nettype wire

### rtl/b64e_front.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_front
    import b64e_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire byte_item_t byte_item,
    input  wire logic       queue_full,
    output logic            queue_push,
    output job_t            queue_job
);

    phase_t     phase_reg, phase_next;
    logic [3:0] carry_reg, carry_next;
    logic [7:0] b;
    logic       fin;
    logic       accept;

    assign b      = byte_item.data_byte;
    assign fin    = byte_item.last_byte;
    assign full   = queue_full;
    assign accept = push && !queue_full;
    assign queue_push = accept;

    always_comb
    begin
        queue_job       = '0;
        queue_job.fin   = fin;
        phase_next      = PHASE_0;
        carry_next      = 4'd0;
        case (phase_reg)
            PHASE_1:
            begin
                queue_job.chars[0] = b64_sym({carry_reg[1:0], b[7:4]});
                if (fin) begin
                    queue_job.chars[1] = b64_sym({b[3:0], 2'b00});
                    queue_job.chars[2] = PAD_CHAR;
                    queue_job.last_idx = 2'd2;
                end else begin
                    queue_job.last_idx = 2'd0;
                    carry_next         = b[3:0];
                    phase_next         = PHASE_2;
                end
            end
            PHASE_2:
            begin
                queue_job.chars[0] = b64_sym({carry_reg, b[7:6]});
                queue_job.chars[1] = b64_sym(b[5:0]);
                queue_job.last_idx = 2'd1;
            end
            default:
            begin
                queue_job.chars[0] = b64_sym(b[7:2]);
                if (fin) begin
                    queue_job.chars[1] = b64_sym({b[1:0], 4'b0000});
                    queue_job.chars[2] = PAD_CHAR;
                    queue_job.chars[3] = PAD_CHAR;
                    queue_job.last_idx = 2'd3;
                end else begin
                    queue_job.last_idx = 2'd0;
                    carry_next         = {2'b00, b[1:0]};
                    phase_next         = PHASE_1;
                end
            end
        endcase
        if (fin) begin
            phase_next = PHASE_0;
            carry_next = 4'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg <= PHASE_0;
            carry_reg <= 4'd0;
        end else if (accept) begin
            phase_reg <= phase_next;
            carry_reg <= carry_next;
        end
    end

endmodule

`default_nettype wire

### rtl/b64e_job_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_job_fifo
    import b64e_pkg::*;
#(
    parameter int unsigned Depth = JOB_DEPTH
)
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic wr_en,
    input  wire job_t wr_job,
    output logic      full,
    input  wire logic rd_en,
    output job_t      rd_job,
    output logic      empty
);

    localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
    localparam int unsigned CntW = $clog2(Depth + 1);

    job_t            mem [Depth];
    logic [PtrW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CntW-1:0] count_reg;
    logic            do_wr, do_rd;

    assign full   = (count_reg == CntW'(Depth));
    assign empty  = (count_reg == '0);
    assign do_wr  = wr_en && !full;
    assign do_rd  = rd_en && !empty;
    assign rd_job = mem[rd_ptr_reg];

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        if (p == PtrW'(Depth - 1)) begin
            ptr_inc = '0;
        end else begin
            ptr_inc = p + 1'b1;
        end
    endfunction

    always_ff @(posedge clk)
    begin
        if (do_wr) begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_wr) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_rd) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_wr && !do_rd) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_rd && !do_wr) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### rtl/b64e_back.sv
`timescale 1ns / 1ps
`default_nettype none

module b64e_back
    import b64e_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic queue_empty,
    input  wire job_t queue_job,
    output logic      queue_pop,
    output logic      empty,
    input  wire logic pop,
    output char_item_t char_item
);

    job_t       job_reg;
    logic [1:0] idx_reg;
    logic       valid_reg;
    logic       done;
    logic       take;

    assign done      = (idx_reg == job_reg.last_idx);
    assign take      = !valid_reg || (pop && done);
    assign queue_pop = take && !queue_empty;
    assign empty     = !valid_reg;

    assign char_item.out_char  = job_reg.chars[idx_reg];
    assign char_item.last_char = job_reg.fin && done;

    // Load the next job when the output is empty or the current one has its last character taken.
    always_ff @(posedge clk)
    begin
        if (queue_pop) begin
            job_reg <= queue_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end else if (take) begin
            valid_reg <= !queue_empty;
            idx_reg   <= 2'd0;
        end else if (pop) begin
            idx_reg   <= idx_reg + 2'd1;
        end
    end

endmodule

`default_nettype wire

### rtl/base64_stream_encoder.sv
// Base64 stream encoder (standard alphabet, '=' padding).
// Input channel: one raw byte per transaction (push/full), with last_byte
// marking the final byte of a message. Output channel: one ASCII character
// per transaction (empty/pop), with last_char on the final character.
// The front stage takes a byte in every cycle that full is low, turns it into
// one to four characters and writes them as one job into a small queue of
// JobDepth entries. The back stage presents those characters one per cycle
// while pop is high. With the output stage idle, the first character of a byte
// passes through the queue and then the output register before it can be
// popped. Throughput: one character per cycle at the output while pop is high
// (four characters per three bytes, plus the flush of a final partial group);
// bytes are taken back to back until the queue fills.
// When the receiver holds pop low, the current character stays on the
// output, the queue fills and full rises; no data is lost.
// Reset empties the queue and the output stage and starts a new group.
`timescale 1ns / 1ps
`default_nettype none

module base64_stream_encoder
    import b64e_pkg::*;
#(
    parameter int unsigned JobDepth = JOB_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    output logic            full,
    input  wire byte_item_t byte_item,
    output logic            empty,
    input  wire logic       pop,
    output char_item_t      char_item
);

    logic q_push, q_full, q_pop, q_empty;
    job_t q_wr_job, q_rd_job;

    b64e_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .byte_item  (byte_item),
        .queue_full (q_full),
        .queue_push (q_push),
        .queue_job  (q_wr_job)
    );

    b64e_job_fifo #(
        .Depth (JobDepth)
    ) u_fifo (
        .clk    (clk),
        .rst_n  (rst_n),
        .wr_en  (q_push),
        .wr_job (q_wr_job),
        .full   (q_full),
        .rd_en  (q_pop),
        .rd_job (q_rd_job),
        .empty  (q_empty)
    );

    b64e_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .queue_empty (q_empty),
        .queue_job   (q_rd_job),
        .queue_pop   (q_pop),
        .empty       (empty),
        .pop         (pop),
        .char_item   (char_item)
    );

endmodule

`default_nettype wire

### tb/sv/base64_stream_encoder_tb.sv
`timescale 1ns / 1ps

module base64_stream_encoder_tb;
    import b64e_pkg::*;

    localparam int unsigned RANDOM_BYTES = 310;
    localparam int unsigned CYCLE_LIMIT = 500000;
    localparam int unsigned SETTLE_CYCLES = 20;
    localparam int unsigned NUM_DIRECTED = 19;

    // Byte and last flag per entry; covers every phase ending a message,
    // all-zero and all-one bytes, and the two punctuation symbols.
    localparam logic [8:0] DIRECTED_BYTES [NUM_DIRECTED] = '{
        {8'h00, 1'b1},
        {8'hFF, 1'b1},
        {8'h00, 1'b0}, {8'hFF, 1'b1},
        {8'hFF, 1'b0}, {8'h00, 1'b1},
        {8'hFB, 1'b0}, {8'hEF, 1'b0}, {8'hBE, 1'b1},
        {8'hFF, 1'b0}, {8'hFF, 1'b0}, {8'hFF, 1'b0},
        {8'h00, 1'b0}, {8'h00, 1'b0}, {8'h00, 1'b1},
        {8'h80, 1'b0}, {8'h7F, 1'b0}, {8'h55, 1'b0}, {8'hAA, 1'b1}
    };

    class char_scoreboard;
        char_item_t  expected_chars[$];
        phase_t      phase;
        logic [3:0]  carry;
        int unsigned mismatches;
        string       alphabet;

        function new();
            phase = PHASE_0;
            carry = '0;
            mismatches = 0;
            alphabet = "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";
        endfunction

        function logic [7:0] symbol(logic [5:0] six);
            return alphabet[int'(six)];
        endfunction

        function void queue_char(logic [7:0] c, logic fin);
            char_item_t ci;
            ci.out_char = c;
            ci.last_char = fin;
            expected_chars.insert(expected_chars.size(), ci);
        endfunction

        // Encode one accepted byte into the characters it completes.
        function void note_byte(byte_item_t item);
            logic [7:0] b;
            b = item.data_byte;
            case (phase)
                PHASE_1:
                begin
                    queue_char(symbol({carry[1:0], b[7:4]}), 1'b0);
                    if (item.last_byte)
                    begin
                        queue_char(symbol({b[3:0], 2'b00}), 1'b0);
                        queue_char(PAD_CHAR, 1'b1);
                        phase = PHASE_0;
                        carry = '0;
                    end
                    else
                    begin
                        carry = b[3:0];
                        phase = PHASE_2;
                    end
                end
                PHASE_2:
                begin
                    queue_char(symbol({carry, b[7:6]}), 1'b0);
                    queue_char(symbol(b[5:0]), item.last_byte);
                    phase = PHASE_0;
                    carry = '0;
                end
                default:
                begin
                    queue_char(symbol(b[7:2]), 1'b0);
                    if (item.last_byte)
                    begin
                        queue_char(symbol({b[1:0], 4'b0000}), 1'b0);
                        queue_char(PAD_CHAR, 1'b0);
                        queue_char(PAD_CHAR, 1'b1);
                        phase = PHASE_0;
                        carry = '0;
                    end
                    else
                    begin
                        carry = {2'b00, b[1:0]};
                        phase = PHASE_1;
                    end
                end
            endcase
        endfunction

        function void check_char(char_item_t got);
            char_item_t want;
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected char %h last %0b", got.out_char, got.last_char);
                return;
            end
            want = expected_chars.pop_front();
            if (got.out_char !== want.out_char || got.last_char !== want.last_char)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("char mismatch: expected %h last %0b, got %h last %0b",
                             want.out_char, want.last_char, got.out_char, got.last_char);
            end
        endfunction

        function int unsigned pending();
            return expected_chars.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        push;
    logic        full;
    byte_item_t  byte_item;
    logic        empty;
    logic        pop;
    char_item_t  char_item;

    char_scoreboard sb;
    int unsigned    cycle_count;
    int unsigned    pop_stall;
    bit             no_idle;
    bit             draining;

    base64_stream_encoder dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .byte_item (byte_item),
        .empty     (empty),
        .pop       (pop),
        .char_item (char_item)
    );

    initial clk = 1'b0;
    always #2 clk = ~clk;

    // Mostly short gaps, a few long ones; none during a quiet stretch.
    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle || draining)
            return 0;
        if (r < 50)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    // Enter and leave at a falling edge; keep push high across back-to-back bytes.
    task automatic send_byte(input byte_item_t item);
        int unsigned gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            push = 1'b0;
            repeat (gap) @(negedge clk);
        end
        push = 1'b1;
        byte_item = item;
        forever
        begin
            @(posedge clk);
            if (!full)
                break;
        end
        sb.note_byte(item);
        @(negedge clk);
    endtask

    task automatic send_random_message(output int unsigned len);
        byte_item_t  item;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(7, 20) : $urandom_range(1, 6);
        no_idle = ($urandom_range(0, 4) == 0);
        for (int unsigned i = 0; i < len; i++)
        begin
            case ($urandom_range(0, 9))
                0: item.data_byte = 8'h00;
                1: item.data_byte = 8'hFF;
                default: item.data_byte = 8'($urandom_range(0, 255));
            endcase
            item.last_byte = (i == len - 1);
            send_byte(item);
        end
    endtask

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("base64_stream_encoder_tb: done, errors");
            $finish;
        end
    end

    // Pop side: sample at the rising edge, drive at the falling edge.
    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
        begin
            sb.check_char(char_item);
            pop_stall = pick_gap();
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
            pop = 1'b0;
        else if (pop_stall > 0)
        begin
            pop = 1'b0;
            pop_stall--;
        end
        else
            pop = 1'b1;
    end

    initial
    begin
        int unsigned sent;
        int unsigned msg_len;
        sb = new();
        cycle_count = 0;
        pop_stall = 0;
        no_idle = 1'b0;
        draining = 1'b0;
        rst_n = 1'b0;
        push = 1'b0;
        pop = 1'b0;
        byte_item = '0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int unsigned i = 0; i < NUM_DIRECTED; i++)
            send_byte(byte_item_t'(DIRECTED_BYTES[i]));

        sent = 0;
        while (sent < RANDOM_BYTES)
        begin
            send_random_message(msg_len);
            sent = sent + msg_len;
        end
        push = 1'b0;

        draining = 1'b1;
        pop_stall = 0;
        while (sb.pending() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);

        if (sb.pending() != 0)
            $display("%0d expected chars never arrived", sb.pending());
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("base64_stream_encoder_tb: done, clean");
        else
            $display("base64_stream_encoder_tb: done, errors");
        $finish;
    end

endmodule
